### rtl/mdro_pkg.sv
// ----------------------------------------------------------------------------
// mdro_pkg
// Types and constants shared by the odometry core's controller and datapath,
// and the CORDIC arctangent table used by the datapath.
// ----------------------------------------------------------------------------
package mdro_pkg;

   localparam int IDX_W = 5;

   localparam logic CSR_LEVER_LENGTH = 1'b0;
   localparam logic CSR_COUNT_TO_CM  = 1'b1;

   localparam logic [11:0] LEVER_RESET = 12'd591;
   localparam logic [23:0] SCALE_RESET = 24'd170459;

   localparam logic signed [35:0] CORDIC_GAIN_INV = 36'sh026DD3B6A;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_DECIDE,
      ST_VEC_ITER,
      ST_HEAD,
      ST_ROT_LOAD,
      ST_ROT_ITER,
      ST_MUL_A,
      ST_MUL_B,
      ST_ACC,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic             capture;
      logic             clear;
      logic             load_vec;
      logic             iter_vec;
      logic             upd_heading;
      logic             load_rot;
      logic             iter_rot;
      logic             mul_a;
      logic             mul_b;
      logic             acc;
      logic             sel_y;
      logic             publish;
      logic [IDX_W-1:0] idx;
   } dp_cmd_type;

   typedef struct packed {
      logic kind;
      logic mx_nonzero;
   } dp_status_type;

   function automatic logic [31:0] atan_entry(input logic [IDX_W-1:0] i);
      logic [31:0] v;
      case (i)
         5'd0:  v = 32'h20000000;
         5'd1:  v = 32'h12E4051E;
         5'd2:  v = 32'h09FB385B;
         5'd3:  v = 32'h051111D4;
         5'd4:  v = 32'h028B0D43;
         5'd5:  v = 32'h0145D7E1;
         5'd6:  v = 32'h00A2F61E;
         5'd7:  v = 32'h00517C55;
         5'd8:  v = 32'h0028BE53;
         5'd9:  v = 32'h00145F2F;
         5'd10: v = 32'h000A2F98;
         5'd11: v = 32'h000517CC;
         5'd12: v = 32'h00028BE6;
         5'd13: v = 32'h000145F3;
         5'd14: v = 32'h0000A2FA;
         5'd15: v = 32'h0000517D;
         5'd16: v = 32'h000028BE;
         5'd17: v = 32'h0000145F;
         5'd18: v = 32'h00000A30;
         5'd19: v = 32'h00000518;
         5'd20: v = 32'h0000028C;
         5'd21: v = 32'h00000146;
         5'd22: v = 32'h000000A3;
         5'd23: v = 32'h00000051;
         default: v = 32'h00000000;
      endcase
      return v;
   endfunction

endpackage

### rtl/mdro_ctrl.sv
// ----------------------------------------------------------------------------
// mdro_ctrl
// Sequencer for the odometry core: steps the shared CORDIC unit through the
// vectoring and rotation runs, then the multiply and accumulate steps.
// ----------------------------------------------------------------------------
module mdro_ctrl #(
   parameter int CORDIC_ITERATIONS = 16
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   input  mdro_pkg::dp_status_type status,
   output mdro_pkg::dp_cmd_type   cmd
);
   import mdro_pkg::*;

   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(CORDIC_ITERATIONS - 1);

   state_type        state_ff, state_in;
   logic [IDX_W-1:0] idx_ff, idx_in;
   logic             axis_ff, axis_in;
   logic             rsp_valid_ff, rsp_valid_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         idx_ff       <= '0;
         axis_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         idx_ff       <= idx_in;
         axis_ff      <= axis_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      state_in     = state_ff;
      idx_in       = idx_ff;
      axis_in      = axis_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      cmd          = '0;
      cmd.idx      = idx_ff;
      cmd.sel_y    = axis_ff;
      req_ready    = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = ST_DECIDE;
            end
         end
         ST_DECIDE: begin
            idx_in  = '0;
            axis_in = 1'b0;
            if (status.kind) begin
               cmd.clear = 1'b1;
               state_in  = ST_DONE;
            end else if (status.mx_nonzero) begin
               cmd.load_vec = 1'b1;
               state_in     = ST_VEC_ITER;
            end else begin
               state_in = ST_ROT_LOAD;
            end
         end
         ST_VEC_ITER: begin
            cmd.iter_vec = 1'b1;
            idx_in       = idx_ff + 1'b1;
            if (idx_ff == LAST_IDX) begin
               state_in = ST_HEAD;
            end
         end
         ST_HEAD: begin
            cmd.upd_heading = 1'b1;
            state_in        = ST_ROT_LOAD;
         end
         ST_ROT_LOAD: begin
            cmd.load_rot = 1'b1;
            idx_in       = '0;
            state_in     = ST_ROT_ITER;
         end
         ST_ROT_ITER: begin
            cmd.iter_rot = 1'b1;
            idx_in       = idx_ff + 1'b1;
            if (idx_ff == LAST_IDX) begin
               state_in = ST_MUL_A;
            end
         end
         ST_MUL_A: begin
            cmd.mul_a = 1'b1;
            state_in  = ST_MUL_B;
         end
         ST_MUL_B: begin
            cmd.mul_b = 1'b1;
            state_in  = ST_ACC;
         end
         ST_ACC: begin
            cmd.acc = 1'b1;
            if (axis_ff) begin
               state_in = ST_DONE;
            end else begin
               axis_in  = 1'b1;
               state_in = ST_MUL_A;
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.publish  = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

### rtl/mdro_datapath.sv
// ----------------------------------------------------------------------------
// mdro_datapath
// Configuration registers, the shared CORDIC unit, the two-step multiplier
// and the saturating position accumulators with the result registers.
// ----------------------------------------------------------------------------
module mdro_datapath #(
   parameter int POS_WIDTH = 32
) (
   input  logic                    clock,
   input  logic                    reset,
   input  mdro_pkg::dp_cmd_type    cmd,
   output mdro_pkg::dp_status_type status,
   input  logic                    req_kind,
   input  logic signed [7:0]       req_mx_count,
   input  logic signed [7:0]       req_my_count,
   input  logic                    csr_valid,
   input  logic                    csr_index,
   input  logic [23:0]             csr_data,
   output logic signed [31:0]      rsp_x_pos,
   output logic signed [31:0]      rsp_y_pos,
   output logic signed [15:0]      rsp_heading
);
   import mdro_pkg::*;

   localparam int SUM_W = ((POS_WIDTH > 26) ? POS_WIDTH : 26) + 1;
   localparam int EXT_W = (POS_WIDTH > 32) ? POS_WIDTH : 32;
   localparam logic signed [SUM_W-1:0] PMAX = SUM_W'((65'sd1 <<< (POS_WIDTH - 1)) - 1);
   localparam logic signed [SUM_W-1:0] PMIN = -PMAX - SUM_W'(1);

   logic [11:0]                  lever_ff;
   logic [23:0]                  scale_ff;
   logic                         kind_ff;
   logic signed [7:0]            mx_ff, my_ff;
   logic signed [35:0]           cx_ff, cy_ff, cz_ff;
   logic                         flip_ff;
   logic signed [15:0]           heading_ff;
   logic signed [POS_WIDTH-1:0]  x_acc_ff, y_acc_ff;
   logic signed [60:0]           prod1_ff;
   logic signed [63:0]           prod2_ff;
   logic signed [31:0]           x_out_ff, y_out_ff;
   logic signed [15:0]           h_out_ff;

   logic signed [35:0]           dx, dy, atan_v, trig, sin_v, cos_v;
   logic signed [35:0]           turn;
   logic signed [16:0]           h_wide, h_adj;
   logic                         h_flip;
   logic signed [68:0]           prod2_w;
   logic signed [63:0]           rounded;
   logic signed [25:0]           delta;
   logic signed [POS_WIDTH-1:0]  acc_sel;
   logic signed [SUM_W-1:0]      sum, sat;
   logic signed [EXT_W-1:0]      x_ext, y_ext;

   always_comb begin
      dx     = cy_ff >>> cmd.idx;
      dy     = cx_ff >>> cmd.idx;
      atan_v = $signed({4'b0000, atan_entry(cmd.idx)});
      turn   = (cz_ff + 36'sd32768) >>> 16;
      h_wide = 17'(heading_ff);
      if (h_wide > 17'sd16384) begin
         h_adj  = h_wide - 17'sd32768;
         h_flip = 1'b1;
      end else if (h_wide < -17'sd16384) begin
         h_adj  = h_wide + 17'sd32768;
         h_flip = 1'b1;
      end else begin
         h_adj  = h_wide;
         h_flip = 1'b0;
      end
      sin_v   = flip_ff ? -cy_ff : cy_ff;
      cos_v   = flip_ff ? -cx_ff : cx_ff;
      trig    = cmd.sel_y ? cos_v : sin_v;
      prod2_w = prod1_ff * (cmd.sel_y ? my_ff : mx_ff);
      rounded = (prod2_ff + 64'sd137438953472) >>> 38;
      delta   = rounded[25:0];
      acc_sel = cmd.sel_y ? y_acc_ff : x_acc_ff;
      sum     = SUM_W'(acc_sel) + SUM_W'(delta);
      if (sum > PMAX) begin
         sat = PMAX;
      end else if (sum < PMIN) begin
         sat = PMIN;
      end else begin
         sat = sum;
      end
      x_ext = EXT_W'(x_acc_ff);
      y_ext = EXT_W'(y_acc_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         lever_ff   <= LEVER_RESET;
         scale_ff   <= SCALE_RESET;
         heading_ff <= '0;
         x_acc_ff   <= '0;
         y_acc_ff   <= '0;
      end else begin
         if (csr_valid) begin
            unique case (csr_index)
               CSR_LEVER_LENGTH: lever_ff <= csr_data[11:0];
               CSR_COUNT_TO_CM:  scale_ff <= csr_data;
               default:          lever_ff <= lever_ff;
            endcase
         end
         if (cmd.clear) begin
            heading_ff <= '0;
            x_acc_ff   <= '0;
            y_acc_ff   <= '0;
         end
         if (cmd.upd_heading) begin
            heading_ff <= heading_ff - turn[15:0];
         end
         if (cmd.acc) begin
            if (cmd.sel_y) begin
               y_acc_ff <= sat[POS_WIDTH-1:0];
            end else begin
               x_acc_ff <= sat[POS_WIDTH-1:0];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         kind_ff <= req_kind;
         mx_ff   <= req_mx_count;
         my_ff   <= req_my_count;
      end
      if (cmd.load_vec) begin
         cx_ff <= $signed({4'b0000, lever_ff, 20'b0});
         cy_ff <= 36'(mx_ff) <<< 20;
         cz_ff <= '0;
      end else if (cmd.load_rot) begin
         cx_ff   <= CORDIC_GAIN_INV;
         cy_ff   <= '0;
         cz_ff   <= 36'(h_adj) <<< 16;
         flip_ff <= h_flip;
      end else if (cmd.iter_vec) begin
         if (cy_ff > 36'sd0) begin
            cx_ff <= cx_ff + dx;
            cy_ff <= cy_ff - dy;
            cz_ff <= cz_ff + atan_v;
         end else begin
            cx_ff <= cx_ff - dx;
            cy_ff <= cy_ff + dy;
            cz_ff <= cz_ff - atan_v;
         end
      end else if (cmd.iter_rot) begin
         if (cz_ff >= 36'sd0) begin
            cx_ff <= cx_ff - dx;
            cy_ff <= cy_ff + dy;
            cz_ff <= cz_ff - atan_v;
         end else begin
            cx_ff <= cx_ff + dx;
            cy_ff <= cy_ff - dy;
            cz_ff <= cz_ff + atan_v;
         end
      end
      if (cmd.mul_a) begin
         prod1_ff <= trig * $signed({1'b0, scale_ff});
      end
      if (cmd.mul_b) begin
         prod2_ff <= prod2_w[63:0];
      end
      if (cmd.publish) begin
         x_out_ff <= x_ext[31:0];
         y_out_ff <= y_ext[31:0];
         h_out_ff <= heading_ff;
      end
   end

   assign status.kind       = kind_ff;
   assign status.mx_nonzero = (mx_ff != 8'sd0);
   assign rsp_x_pos         = x_out_ff;
   assign rsp_y_pos         = y_out_ff;
   assign rsp_heading       = h_out_ff;

endmodule

### rtl/mouse_dead_reckoning_odometry_core.sv
// ----------------------------------------------------------------------------
// mouse_dead_reckoning_odometry_core
// Dead-reckoning odometry from optical-mouse motion reports, one request at
// a time through a shared CORDIC unit and a two-step multiplier.
// ----------------------------------------------------------------------------
// Sequence: a motion request runs the CORDIC vectoring and rotation runs,
// then the multiplies; without x motion the vectoring run is skipped, and a
// clear goes straight to the result. A new request is taken only once the
// last result has been published to the output registers.
// Reset: position and heading clear to zero, registers take their defaults.
module mouse_dead_reckoning_odometry_core #(
   parameter int CORDIC_ITERATIONS = 16,
   parameter int POS_WIDTH         = 32
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic               req_kind,
   input  logic signed [7:0]  req_mx_count,
   input  logic signed [7:0]  req_my_count,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic signed [31:0] rsp_x_pos,
   output logic signed [31:0] rsp_y_pos,
   output logic signed [15:0] rsp_heading,
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic               csr_index,
   input  logic [23:0]        csr_data
);
   import mdro_pkg::*;

   dp_cmd_type    cmd;
   dp_status_type status;

   mdro_ctrl #(
      .CORDIC_ITERATIONS(CORDIC_ITERATIONS)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .status    (status),
      .cmd       (cmd)
   );

   mdro_datapath #(
      .POS_WIDTH(POS_WIDTH)
   ) u_datapath (
      .clock        (clock),
      .reset        (reset),
      .cmd          (cmd),
      .status       (status),
      .req_kind     (req_kind),
      .req_mx_count (req_mx_count),
      .req_my_count (req_my_count),
      .csr_valid    (csr_valid),
      .csr_index    (csr_index),
      .csr_data     (csr_data),
      .rsp_x_pos    (rsp_x_pos),
      .rsp_y_pos    (rsp_y_pos),
      .rsp_heading  (rsp_heading)
   );

   assign csr_ready = 1'b1;

endmodule

### rtl/mdro_checker.sv
// ----------------------------------------------------------------------------
// mdro_checker
// Port-level checks on the odometry core, bound to the top level.
// ----------------------------------------------------------------------------
module mdro_checker (
   input logic               clock,
   input logic               reset,
   input logic               req_valid,
   input logic               req_ready,
   input logic               rsp_valid,
   input logic               rsp_ready,
   input logic signed [31:0] rsp_x_pos,
   input logic signed [31:0] rsp_y_pos,
   input logic signed [15:0] rsp_heading
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_x_pos)
         && $stable(rsp_y_pos) && $stable(rsp_heading))
      else $error("Result changed while stalled.");

   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("Result shown straight after reset.");

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("Second request taken while one is in work.");

   a_no_instant_result: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && !rsp_valid |=> !rsp_valid)
      else $error("Result appeared one cycle after acceptance.");

endmodule

bind mouse_dead_reckoning_odometry_core mdro_checker u_mdro_checker (
   .clock       (clock),
   .reset       (reset),
   .req_valid   (req_valid),
   .req_ready   (req_ready),
   .rsp_valid   (rsp_valid),
   .rsp_ready   (rsp_ready),
   .rsp_x_pos   (rsp_x_pos),
   .rsp_y_pos   (rsp_y_pos),
   .rsp_heading (rsp_heading)
);

### sim/tb_mouse_dead_reckoning_odometry_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_mouse_dead_reckoning_odometry_core
// Self-checking bench for the odometry core. A table of directed requests is
// followed by random motion reports under several lever and scale settings.
// Each result is compared with a behavioural CORDIC predictor of position
// and heading, or with a pinned value on some directed rows. The sender
// runs in bursts and the receiver stalls on a pattern of its own,
// including one long hold-off.
module tb_mouse_dead_reckoning_odometry_core;
   import mdro_pkg::*;

   localparam int ITERS     = 16;
   localparam int LATENCY   = 2 * ITERS + 11;
   localparam int WDOG_MAX  = 20000;
   localparam longint POS_HI = 64'sd2147483647;
   localparam longint POS_LO = -64'sd2147483648;

   typedef struct packed {
      logic signed [31:0] x;
      logic signed [31:0] y;
      logic signed [15:0] h;
   } odo_type;

   typedef struct {
      logic              kind;
      logic signed [7:0] mx;
      logic signed [7:0] my;
      logic              pinned;
      odo_type           want;
   } row_type;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_ready;
   logic               req_kind = 1'b0;
   logic signed [7:0]  req_mx_count = '0;
   logic signed [7:0]  req_my_count = '0;
   logic               rsp_valid;
   logic               rsp_ready = 1'b0;
   logic signed [31:0] rsp_x_pos;
   logic signed [31:0] rsp_y_pos;
   logic signed [15:0] rsp_heading;
   logic               csr_valid = 1'b0;
   logic               csr_ready;
   logic               csr_index = CSR_LEVER_LENGTH;
   logic [23:0]        csr_data = '0;

   logic               pin_use = 1'b0;
   odo_type            pin_want = '0;

   odo_type            odo_expected[$];
   int                 fail_count = 0;
   int                 idle_cycles = 0;
   int                 burst_left = 0;
   int                 long_hold = 0;
   int                 hold_requests = 0;
   int                 hold_seen = 0;

   logic [11:0]        lever_len;
   logic [23:0]        cm_scale;
   longint             x_track, y_track;
   logic [15:0]        head_track;

   mouse_dead_reckoning_odometry_core u_top (.*);

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic longint turn_angle(longint yv, longint xv);
      longint x, y, z, dx, dy;
      x = xv; y = yv; z = 0;
      for (int i = 0; i < ITERS; i++) begin
         dx = y >>> i;
         dy = x >>> i;
         if (y > 0) begin
            x += dx; y -= dy; z += longint'(atan_tab(i));
         end else begin
            x -= dx; y += dy; z -= longint'(atan_tab(i));
         end
      end
      return z;
   endfunction

   function automatic logic [31:0] atan_tab(int i);
      logic [31:0] t [24] = '{
         32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
         32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
         32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
         32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
         32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
         32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051};
      return t[i];
   endfunction

   task automatic heading_trig(input int hin, output longint s, output longint c);
      longint x, y, z, dx, dy;
      int h;
      bit flip;
      h = hin; flip = 0;
      if (h > 16384) begin
         h -= 32768; flip = 1;
      end else if (h < -16384) begin
         h += 32768; flip = 1;
      end
      x = 64'h26DD3B6A; y = 0; z = longint'(h) * 65536;
      for (int i = 0; i < ITERS; i++) begin
         dx = y >>> i;
         dy = x >>> i;
         if (z >= 0) begin
            x -= dx; y += dy; z -= longint'(atan_tab(i));
         end else begin
            x += dx; y -= dy; z += longint'(atan_tab(i));
         end
      end
      s = flip ? -y : y;
      c = flip ? -x : x;
   endtask

   function automatic longint clamp_pos(longint v);
      if (v > POS_HI) return POS_HI;
      if (v < POS_LO) return POS_LO;
      return v;
   endfunction

   task automatic advance_odometry(input logic kind, input logic signed [7:0] mx,
                                   input logic signed [7:0] my, output odo_type res);
      longint z, a16, s, c, dx, dy, m, n;
      if (kind) begin
         x_track = 0; y_track = 0; head_track = '0;
      end else begin
         m = longint'(mx);
         n = longint'(my);
         if (mx != 0) begin
            z = turn_angle(m * 1048576, longint'(lever_len) * 1048576);
            a16 = (z + 32768) >>> 16;
            head_track = head_track - a16[15:0];
         end
         heading_trig(int'($signed(head_track)), s, c);
         dx = (m * s * longint'(cm_scale) + (64'sd1 <<< 37)) >>> 38;
         dy = (n * c * longint'(cm_scale) + (64'sd1 <<< 37)) >>> 38;
         x_track = clamp_pos(x_track + dx);
         y_track = clamp_pos(y_track + dy);
      end
      res.x = x_track[31:0];
      res.y = y_track[31:0];
      res.h = head_track;
   endtask

   task automatic report_mismatch(string field, longint got, longint want);
      $display("%0t mismatch on %s: got %0d, want %0d", $realtime, field, got, want);
      fail_count++;
   endtask

   // Prediction at request acceptance, checking at result acceptance.
   always @(posedge clock) begin
      odo_type p, w;
      if (reset) begin
         lever_len = LEVER_RESET;
         cm_scale  = SCALE_RESET;
         x_track = 0; y_track = 0; head_track = '0;
      end else begin
         if (csr_valid && csr_ready) begin
            if (csr_index == CSR_LEVER_LENGTH) lever_len = csr_data[11:0];
            else cm_scale = csr_data;
         end
         if (req_valid && req_ready) begin
            advance_odometry(req_kind, req_mx_count, req_my_count, p);
            odo_expected.push_back(pin_use ? pin_want : p);
         end
         if (rsp_valid && rsp_ready) begin
            if (odo_expected.size() == 0) begin
               $display("%0t result with no request outstanding", $realtime);
               fail_count++;
            end else begin
               w = odo_expected.pop_front();
               if (rsp_x_pos !== w.x) report_mismatch("x_pos", rsp_x_pos, w.x);
               if (rsp_y_pos !== w.y) report_mismatch("y_pos", rsp_y_pos, w.y);
               if (rsp_heading !== w.h) report_mismatch("heading", rsp_heading, w.h);
            end
         end
      end
   end

   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || (csr_valid && csr_ready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WDOG_MAX) begin
         $display("TEST FAILED");
         $finish;
      end
   end

   // Receiver stall pattern with an optional long hold-off.
   always @(posedge clock) begin
      int mode, left;
      if (reset) begin
         rsp_ready <= 1'b0;
         mode = 0; left = 0;
      end else if (hold_requests != hold_seen) begin
         rsp_ready <= 1'b0;
         long_hold <= 400;
         hold_seen <= hold_requests;
      end else if (long_hold > 0) begin
         rsp_ready <= 1'b0;
         long_hold <= long_hold - 1;
      end else begin
         if (left == 0) begin
            mode = $urandom_range(0, 3);
            left = $urandom_range(5, 120);
         end
         left--;
         case (mode)
            0: rsp_ready <= 1'b1;
            1: rsp_ready <= 1'($urandom_range(0, 1));
            2: rsp_ready <= ($urandom_range(0, 7) == 0);
            default: rsp_ready <= ($urandom_range(0, 3) != 0);
         endcase
      end
   end

   task automatic send_request(input logic kind, input logic signed [7:0] mx,
                               input logic signed [7:0] my, input logic pin,
                               input odo_type want);
      bit hs;
      if (burst_left == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 12)) @(posedge clock);
         burst_left = $urandom_range(1, 20);
      end
      burst_left--;
      req_valid    <= 1'b1;
      req_kind     <= kind;
      req_mx_count <= mx;
      req_my_count <= my;
      pin_use      <= pin;
      pin_want     <= want;
      forever begin
         @(negedge clock);
         hs = req_ready;
         @(posedge clock);
         if (hs) break;
      end
   endtask

   task automatic write_register(input logic idx, input logic [23:0] value);
      bit hs;
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      forever begin
         @(negedge clock);
         hs = csr_ready;
         @(posedge clock);
         if (hs) break;
      end
      csr_valid <= 1'b0;
   endtask

   task automatic drain_block;
      req_valid <= 1'b0;
      burst_left = 0;
      while (odo_expected.size() != 0) @(posedge clock);
      repeat (LATENCY + 10) @(posedge clock);
   endtask

   task automatic random_motion(input int count, input int bias);
      logic signed [7:0] mx, my;
      logic k;
      odo_type none;
      none = '0;
      for (int n = 0; n < count; n++) begin
         k = ($urandom_range(0, 39) == 0);
         mx = 8'($urandom);
         my = 8'($urandom);
         case ($urandom_range(0, 9))
            0: mx = 8'sd0;
            1: mx = ($urandom_range(0, 1)) ? 8'sd127 : -8'sd128;
            2: my = ($urandom_range(0, 1)) ? 8'sd127 : -8'sd128;
            default: ;
         endcase
         if (bias == 1 && $urandom_range(0, 3) != 0) begin
            mx = 8'sd0;
            my = 8'sd127;
            k = 1'b0;
         end
         if (n == count / 2 && bias == 2) hold_requests = hold_requests + 1;
         send_request(k, mx, my, 1'b0, none);
      end
      drain_block();
   endtask

   initial begin
      row_type dir [$];
      odo_type zero;
      zero = '0;
      dir.push_back('{1'b0, 8'sd0, 8'sd0, 1'b1, zero});
      dir.push_back('{1'b1, 8'sd127, -8'sd128, 1'b1, zero});
      dir.push_back('{1'b0, 8'sd127, 8'sd127, 1'b0, zero});
      dir.push_back('{1'b0, -8'sd128, -8'sd128, 1'b0, zero});
      dir.push_back('{1'b0, 8'sd0, 8'sd127, 1'b0, zero});
      dir.push_back('{1'b0, 8'sd0, -8'sd128, 1'b0, zero});
      dir.push_back('{1'b0, 8'sd1, 8'sd0, 1'b0, zero});
      dir.push_back('{1'b0, -8'sd1, 8'sd1, 1'b0, zero});
      for (int i = 0; i < 10; i++)
         dir.push_back('{1'b0, 8'sd127, 8'sd64, 1'b0, zero});
      for (int i = 0; i < 5; i++)
         dir.push_back('{1'b0, -8'sd128, -8'sd64, 1'b0, zero});
      dir.push_back('{1'b1, -8'sd1, -8'sd1, 1'b1, zero});
      dir.push_back('{1'b0, 8'sd0, 8'sd0, 1'b1, zero});

      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (dir[i]) send_request(dir[i].kind, dir[i].mx, dir[i].my,
                                    dir[i].pinned, dir[i].want);
      pin_use <= 1'b0;
      drain_block();
      random_motion(270, 2);

      write_register(CSR_LEVER_LENGTH, 24'hFFFFFF);
      write_register(CSR_COUNT_TO_CM, 24'hFFFFFF);
      random_motion(270, 0);
      random_motion(300, 1);

      write_register(CSR_LEVER_LENGTH, 24'd1);
      write_register(CSR_COUNT_TO_CM, 24'd1);
      random_motion(170, 0);

      write_register(CSR_LEVER_LENGTH, 24'd0);
      write_register(CSR_COUNT_TO_CM, 24'h800000);
      random_motion(170, 0);

      write_register(CSR_LEVER_LENGTH,
                     24'(($urandom_range(0, 1) << 12) | $urandom_range(1, 4095)));
      write_register(CSR_COUNT_TO_CM, 24'($urandom));
      random_motion(170, 0);

      if (fail_count == 0 && odo_expected.size() == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule

### filelist.f
rtl/mdro_pkg.sv
rtl/mdro_ctrl.sv
rtl/mdro_datapath.sv
rtl/mouse_dead_reckoning_odometry_core.sv
rtl/mdro_checker.sv
sim/tb_mouse_dead_reckoning_odometry_core.sv
